@@ design/capture_pair_frequency_meter_defines.svh @@
// Assertion macros for the capture pair frequency meter.
// Used by the RTL files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef CAPTURE_PAIR_FREQUENCY_METER_DEFINES_SVH
`define CAPTURE_PAIR_FREQUENCY_METER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define CPFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CPFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CPFM_ASSERT(lbl, prop, msg)
`define CPFM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ design/cpfm_pkg.sv @@
// Shared types, widths and register codes of the capture pair frequency meter.
// No dependencies.
package cpfm_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned FreqW  = 24;
  localparam int unsigned LevelW = 2;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned AddrW  = $clog2(NumRegs) + 2;
  localparam int unsigned DataW  = 32;
  localparam int unsigned DefaultQueueDepth = 2;

  localparam logic [FreqW-1:0] RateReset     = FreqW'(250000);
  localparam logic [FreqW-1:0] LevelOneReset = FreqW'(10);
  localparam logic [FreqW-1:0] LevelTwoReset = FreqW'(100);
  localparam logic [FreqW-1:0] LevelThrReset = FreqW'(1000);

  typedef logic [TickW-1:0]  tick_t;
  typedef logic [FreqW-1:0]  freq_t;
  typedef logic [LevelW-1:0] level_t;

  typedef enum logic [$clog2(NumRegs)-1:0] {
    RegTimerRate,
    RegLevelOne,
    RegLevelTwo,
    RegLevelThree
  } reg_idx_e;

  typedef enum logic [LevelW-1:0] {
    LevelZero,
    LevelOne,
    LevelTwo,
    LevelThree
  } level_e;

  // Configuration seen by the back end.
  typedef struct packed {
    freq_t rate;
    freq_t limit_one;
    freq_t limit_two;
    freq_t limit_three;
  } cfg_t;

  // Queue write side.
  typedef struct packed {
    logic  valid;
    tick_t ticks;
  } push_t;

  // Queue read side status.
  typedef struct packed {
    logic  valid;
    tick_t ticks;
  } head_t;

endpackage

@@ design/cpfm_cap_if.sv @@
// Capture channel: valid/ready handshake carrying one timer capture per beat.
// Depends on cpfm_pkg.
interface cpfm_cap_if
  import cpfm_pkg::*;
();
  logic  valid;
  logic  ready;
  tick_t capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

@@ design/cpfm_res_if.sv @@
// Result channel: valid/ready handshake carrying ticks, frequency and level per beat.
// Depends on cpfm_pkg.
interface cpfm_res_if
  import cpfm_pkg::*;
();
  logic   valid;
  logic   ready;
  tick_t  tick_count;
  freq_t  frequency_hz;
  level_t range_level;

  modport source (output valid, output tick_count, output frequency_hz,
                  output range_level, input ready);
  modport sink   (input valid, input tick_count, input frequency_hz,
                  input range_level, output ready);
endinterface

@@ design/capture_pair_frequency_meter.sv @@
// Capture pair frequency meter: takes 16-bit timer captures in disjoint pairs. The first
// capture of a pair is stored and gives no result; the second gives one result beat with
// the tick difference mod 65536, timer_rate_hz / ticks (floor) and a range level 0..3
// from three limit registers tested in order. Zero ticks repeats the last frequency
// (0 after reset). A first capture is always accepted and only stored. A second capture is
// queued (QueueDepth entries); the back end pops it, runs the restoring one-bit-a-cycle
// divider and then loads the result register once that register is free; a zero-tick
// pair skips the divider. The divider sets the sustained rate.
// The capture side keeps accepting while the queue has room, even when a result waits.
// Registers on the APB port (byte address 4*i, 24 bits used, pready always high):
// 0 timer_rate_hz, 1 level_one_limit, 2 level_two_limit, 3 level_three_limit. Write them
// only with no pair in flight; the back end reads them live.
// Depends on cpfm_pkg, cpfm_cap_if, cpfm_res_if, cpfm_front, cpfm_queue, cpfm_back.
module capture_pair_frequency_meter
  import cpfm_pkg::*;
#(
  parameter int unsigned QueueDepth = DefaultQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output logic [DataW-1:0] prdata_o,
  output logic             pready_o,
  cpfm_cap_if.sink         cap,
  cpfm_res_if.source       res
);

  // --- configuration registers ---
  freq_t    rate_q, lim1_q, lim2_q, lim3_q;
  logic     wr_en;
  reg_idx_e reg_idx;
  freq_t    rd_val;
  cfg_t     cfg;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_idx  = reg_idx_e'(paddr_i[AddrW-1:2]);   // byte offset ignored

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RateReset;
      lim1_q <= LevelOneReset;
      lim2_q <= LevelTwoReset;
      lim3_q <= LevelThrReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegTimerRate:  rate_q <= pwdata_i[FreqW-1:0];
        RegLevelOne:   lim1_q <= pwdata_i[FreqW-1:0];
        RegLevelTwo:   lim2_q <= pwdata_i[FreqW-1:0];
        RegLevelThree: lim3_q <= pwdata_i[FreqW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegTimerRate:  rd_val = rate_q;
      RegLevelOne:   rd_val = lim1_q;
      RegLevelTwo:   rd_val = lim2_q;
      RegLevelThree: rd_val = lim3_q;
      default:       rd_val = '0;
    endcase
  end

  assign prdata_o = {{(DataW - FreqW){1'b0}}, rd_val};

  assign cfg.rate        = rate_q;
  assign cfg.limit_one   = lim1_q;
  assign cfg.limit_two   = lim2_q;
  assign cfg.limit_three = lim3_q;

  // --- datapath: front pairs captures, queue decouples, back divides ---
  push_t push;
  head_t head;
  logic  q_ready;
  logic  pop;

  cpfm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cap       (cap),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  cpfm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  cpfm_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .head_i (head),
    .pop_o  (pop),
    .res    (res)
  );

endmodule

@@ design/cpfm_front.sv @@
// Front end: pairs incoming captures and pushes the tick difference to the queue.
// Depends on cpfm_pkg and cpfm_cap_if.
module cpfm_front
  import cpfm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  cpfm_cap_if.sink      cap,
  input  logic          q_ready_i,
  output push_t         push_o
);

  logic  awaiting_q, awaiting_d;
  tick_t first_q, first_d;
  logic  accept;

  // First captures never touch the queue, so only the second one waits for room.
  assign cap.ready = !awaiting_q || q_ready_i;
  assign accept    = cap.valid && cap.ready;

  always_comb begin
    awaiting_d = awaiting_q;
    first_d    = first_q;
    if (accept) begin
      awaiting_d = !awaiting_q;
      if (!awaiting_q) begin
        first_d = cap.capture_time;
      end
    end
  end

  assign push_o.valid = accept && awaiting_q;
  assign push_o.ticks = cap.capture_time - first_q;  // wraps mod 2^16

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      first_q    <= '0;
    end else begin
      awaiting_q <= awaiting_d;
      first_q    <= first_d;
    end
  end

endmodule

@@ design/cpfm_queue.sv @@
// Short tick queue between front and back end.
// Depends on cpfm_pkg and the assertion macro header.
`include "capture_pair_frequency_meter_defines.svh"

module cpfm_queue
  import cpfm_pkg::*;
#(
  parameter int unsigned Depth = DefaultQueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   ready_o,
  output head_t  head_o,
  input  logic   pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  tick_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o      = (cnt_q != DepthCnt);
  assign head_o.valid = (cnt_q != '0);
  assign head_o.ticks = mem_q[rd_q];

  assign do_push = push_i.valid && ready_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.ticks;
    end
  end

  `CPFM_ASSERT(a_cnt_bound, cnt_q <= DepthCnt, "queue fill count above depth")
  `CPFM_ASSERT(a_no_overflow, !(push_i.valid && !ready_o), "push into full queue")
  `CPFM_ASSERT_NEXT(a_drain_empty, cnt_q == CntW'(1) && do_pop && !do_push, !head_o.valid,
                    "queue not empty after popping last entry")

endmodule

@@ design/cpfm_back.sv @@
// Back end: bit-serial division of rate by ticks, range level and result register.
// Depends on cpfm_pkg and cpfm_res_if.
module cpfm_back
  import cpfm_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  head_t         head_i,
  output logic          pop_o,
  cpfm_res_if.source    res
);

  localparam int unsigned Steps = FreqW;
  localparam int unsigned CntW  = $clog2(Steps);
  localparam logic [CntW-1:0] LastStep = CntW'(Steps - 1);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } state_e;

  state_e          state_q;
  tick_t           ticks_q;
  tick_t           rem_q;
  freq_t           sr_q;    // dividend shifts out, quotient shifts in
  logic [CntW-1:0] cnt_q;
  freq_t           held_q;
  logic            out_valid_q;
  tick_t           out_ticks_q;
  freq_t           out_freq_q;
  level_t          out_level_q;

  logic [TickW:0]  trial;
  logic [TickW:0]  diff;
  logic            ge;
  tick_t           rem_next;
  freq_t           sr_next;
  level_e          level;
  logic            out_free;

  assign trial    = {rem_q, sr_q[FreqW-1]};
  assign diff     = trial - {1'b0, ticks_q};
  assign ge       = (trial >= {1'b0, ticks_q});
  assign rem_next = ge ? diff[TickW-1:0] : trial[TickW-1:0];
  assign sr_next  = {sr_q[FreqW-2:0], ge};

  // Limits are tested in order; the first one not reached decides.
  always_comb begin
    priority if (held_q < cfg_i.limit_one) begin
      level = LevelZero;
    end else if (held_q < cfg_i.limit_two) begin
      level = LevelOne;
    end else if (held_q < cfg_i.limit_three) begin
      level = LevelTwo;
    end else begin
      level = LevelThree;
    end
  end

  assign out_free = !out_valid_q || res.ready;
  assign pop_o    = (state_q == StIdle) && head_i.valid;

  assign res.valid        = out_valid_q;
  assign res.tick_count   = out_ticks_q;
  assign res.frequency_hz = out_freq_q;
  assign res.range_level  = out_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ticks_q     <= '0;
      rem_q       <= '0;
      sr_q        <= '0;
      cnt_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      out_ticks_q <= '0;
      out_freq_q  <= '0;
      out_level_q <= '0;
    end else begin
      // in StDone a taken beat is replaced below, so clear only elsewhere
      if (out_valid_q && res.ready && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (head_i.valid) begin
            ticks_q <= head_i.ticks;
            rem_q   <= '0;
            sr_q    <= cfg_i.rate;
            cnt_q   <= '0;
            // zero ticks: skip the divide, held frequency stands
            state_q <= (head_i.ticks == '0) ? StDone : StDiv;
          end
        end
        StDiv: begin
          rem_q <= rem_next;
          sr_q  <= sr_next;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastStep) begin
            held_q  <= sr_next;
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ticks_q <= ticks_q;
            out_freq_q  <= held_q;
            out_level_q <= level_t'(level);
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule
